>>> src/ptl_pkg.sv
// ---------------------------------------------------------------------------
// ptl_pkg: shared types for the pedestrian traffic light controller
// Phase codes, register index codes and fixed field widths.
// ---------------------------------------------------------------------------
package ptl_pkg;

   // fixed widths of the register data and index fields
   localparam int DUR_W   = 8;
   localparam int CSR_A_W = 2;

   // controller phases
   typedef enum logic [3:0] {
      PH_CAR_GREEN         = 4'd0,
      PH_CAR_YELLOW        = 4'd1,
      PH_CAR_RED           = 4'd2,
      PH_YELLOW_AFTER_RED  = 4'd3,
      PH_EXT_RED           = 4'd4,
      PH_YELLOW_AFTER_EXT  = 4'd5,
      PH_PED_BLINK_GREEN   = 4'd6,
      PH_PED_BLINK_YELLOW  = 4'd7,
      PH_PED_WALK          = 4'd8,
      PH_PED_FINAL_BLINK   = 4'd9
   } phase_type;

   // configuration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_GREEN_TICKS = 2'd0,
      CSR_RED_TICKS   = 2'd1,
      CSR_BLINK_TICKS = 2'd2
   } csr_idx_type;

   // duration selector per phase
   typedef enum logic [1:0] {
      DUR_GREEN = 2'd0,
      DUR_RED   = 2'd1,
      DUR_BLINK = 2'd2
   } dur_sel_type;

   // lamp outputs of one response
   typedef struct packed {
      logic car_green;
      logic car_yellow;
      logic car_red;
      logic walk_green;
      logic walk_yellow;
      logic walk_red;
      logic ped_mode_lamp;
   } lamp_type;

endpackage

>>> src/ptl_if.sv
// ---------------------------------------------------------------------------
// ptl interfaces: request, response and register write channels
// Valid/ready channels with source and sink modports.
// ---------------------------------------------------------------------------

// request channel: one time slot
interface ptl_req_if;
   logic valid;
   logic ready;
   logic second_tick;
   logic button_press;

   modport source (output valid, output second_tick, output button_press, input ready);
   modport sink   (input valid, input second_tick, input button_press, output ready);
endinterface

// response channel: lamp state after the slot
interface ptl_rsp_if;
   logic valid;
   logic ready;
   logic car_green;
   logic car_yellow;
   logic car_red;
   logic walk_green;
   logic walk_yellow;
   logic walk_red;
   logic ped_mode_lamp;

   modport source (output valid, output car_green, output car_yellow, output car_red,
                   output walk_green, output walk_yellow, output walk_red,
                   output ped_mode_lamp, input ready);
   modport sink   (input valid, input car_green, input car_yellow, input car_red,
                   input walk_green, input walk_yellow, input walk_red,
                   input ped_mode_lamp, output ready);
endinterface

// register write channel
interface ptl_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ptl_pkg::CSR_A_W-1:0]  index;
   logic [ptl_pkg::DUR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/pedestrian_traffic_light_ctrl_top.sv
// ---------------------------------------------------------------------------
// pedestrian_traffic_light_ctrl_top: car and pedestrian lamp sequencer
// Response: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the response is taken; the phase and
// tick counter update in one pass of next-state logic, and a stalled sink holds off requests.
// Reset: synchronous, active high; phase car green, counter zero, pedestrian
// sequence idle, durations 5 seconds, response channel empty.
// ---------------------------------------------------------------------------
module pedestrian_traffic_light_ctrl_top #(
   parameter int TICK_COUNT_WIDTH = 8
) (
   input logic       clock,
   input logic       reset,
   ptl_req_if.sink   req_if,
   ptl_rsp_if.source rsp_if,
   ptl_csr_if.sink   csr_if
);

   localparam int CNT_W = TICK_COUNT_WIDTH;
   localparam int CMP_W = (CNT_W + 1 > ptl_pkg::DUR_W) ? CNT_W + 1 : ptl_pkg::DUR_W;
   localparam logic [ptl_pkg::DUR_W-1:0] DUR_RESET = ptl_pkg::DUR_W'(5);

   // state and configuration registers
   ptl_pkg::phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]            ticks_ff, ticks_in;
   logic                        busy_ff, busy_in;
   logic                        latch_ff, latch_in;
   logic [ptl_pkg::DUR_W-1:0]   green_ff, red_ff, blink_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptl_pkg::lamp_type           lamp_ff, lamp_in;

   logic                        req_accept;
   logic                        started;
   logic [CNT_W:0]              tick_next;
   logic [ptl_pkg::DUR_W-1:0]   dur;
   ptl_pkg::phase_type          phase_after;
   logic                        blink;

   // phase order of the sequence
   function automatic ptl_pkg::phase_type next_phase(input ptl_pkg::phase_type p);
      ptl_pkg::phase_type r;
      unique case (p)
         ptl_pkg::PH_CAR_GREEN:        r = ptl_pkg::PH_CAR_YELLOW;
         ptl_pkg::PH_CAR_YELLOW:       r = ptl_pkg::PH_CAR_RED;
         ptl_pkg::PH_CAR_RED:          r = ptl_pkg::PH_YELLOW_AFTER_RED;
         ptl_pkg::PH_EXT_RED:          r = ptl_pkg::PH_YELLOW_AFTER_EXT;
         ptl_pkg::PH_PED_BLINK_GREEN:  r = ptl_pkg::PH_PED_WALK;
         ptl_pkg::PH_PED_BLINK_YELLOW: r = ptl_pkg::PH_PED_WALK;
         ptl_pkg::PH_PED_WALK:         r = ptl_pkg::PH_PED_FINAL_BLINK;
         default:                      r = ptl_pkg::PH_CAR_GREEN;
      endcase
      return r;
   endfunction

   // which duration register times each phase
   function automatic ptl_pkg::dur_sel_type dur_sel(input ptl_pkg::phase_type p);
      ptl_pkg::dur_sel_type r;
      unique case (p)
         ptl_pkg::PH_CAR_GREEN: r = ptl_pkg::DUR_GREEN;
         ptl_pkg::PH_CAR_RED,
         ptl_pkg::PH_EXT_RED,
         ptl_pkg::PH_PED_WALK:  r = ptl_pkg::DUR_RED;
         default:               r = ptl_pkg::DUR_BLINK;
      endcase
      return r;
   endfunction

   // handshakes
   assign req_accept    = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;

   // duration of the current phase
   always_comb begin
      unique case (dur_sel(phase_ff))
         ptl_pkg::DUR_GREEN: dur = green_ff;
         ptl_pkg::DUR_RED:   dur = red_ff;
         default:            dur = blink_ff;
      endcase
   end

   assign tick_next   = {1'b0, ticks_ff} + (CNT_W + 1)'(1);
   assign phase_after = next_phase(phase_ff);

   // next state: button press first, then the second tick
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      busy_in  = busy_ff;
      latch_in = latch_ff;
      started  = 1'b0;

      if (req_if.button_press && !busy_ff) begin
         unique case (phase_ff) inside
            ptl_pkg::PH_CAR_RED: begin
               phase_in = ptl_pkg::PH_EXT_RED;
               ticks_in = '0;
               busy_in  = 1'b1;
               started  = 1'b1;
            end
            ptl_pkg::PH_CAR_GREEN: begin
               phase_in = ptl_pkg::PH_PED_BLINK_GREEN;
               ticks_in = '0;
               busy_in  = 1'b1;
               latch_in = 1'b1;
               started  = 1'b1;
            end
            ptl_pkg::PH_CAR_YELLOW, ptl_pkg::PH_YELLOW_AFTER_RED: begin
               phase_in = ptl_pkg::PH_PED_BLINK_YELLOW;
               ticks_in = '0;
               busy_in  = 1'b1;
               latch_in = 1'b1;
               started  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (req_if.second_tick && !started) begin
         // phase ends at its duration or when the counter would wrap
         if (tick_next[CNT_W] || (CMP_W'(tick_next) >= CMP_W'(dur))) begin
            phase_in = phase_after;
            ticks_in = '0;
            if (phase_after == ptl_pkg::PH_CAR_GREEN) begin
               busy_in  = 1'b0;
               latch_in = 1'b0;
            end
         end else begin
            ticks_in = tick_next[CNT_W-1:0];
         end
      end
   end

   // lamp map of the new state, blinking lamps on at even counts
   assign blink = !ticks_in[0];

   always_comb begin
      lamp_in = '0;
      lamp_in.ped_mode_lamp = latch_in;
      unique case (phase_in)
         ptl_pkg::PH_CAR_GREEN: begin
            lamp_in.car_green = 1'b1;
            lamp_in.walk_red  = 1'b1;
         end
         ptl_pkg::PH_CAR_YELLOW: begin
            lamp_in.car_yellow = blink;
            lamp_in.walk_red   = 1'b1;
         end
         ptl_pkg::PH_CAR_RED, ptl_pkg::PH_EXT_RED, ptl_pkg::PH_PED_WALK: begin
            lamp_in.car_red    = 1'b1;
            lamp_in.walk_green = 1'b1;
         end
         ptl_pkg::PH_YELLOW_AFTER_RED, ptl_pkg::PH_YELLOW_AFTER_EXT: begin
            lamp_in.car_yellow = blink;
            lamp_in.walk_green = 1'b1;
         end
         ptl_pkg::PH_PED_BLINK_GREEN: begin
            lamp_in.car_green   = 1'b1;
            lamp_in.car_yellow  = blink;
            lamp_in.walk_yellow = blink;
            lamp_in.walk_red    = 1'b1;
         end
         ptl_pkg::PH_PED_BLINK_YELLOW: begin
            lamp_in.car_yellow  = blink;
            lamp_in.walk_yellow = blink;
            lamp_in.walk_red    = 1'b1;
         end
         default: begin
            lamp_in.car_yellow  = blink;
            lamp_in.walk_yellow = blink;
            lamp_in.walk_green  = 1'b1;
         end
      endcase
   end

   // response valid: set by a request, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ptl_pkg::PH_CAR_GREEN;
         ticks_ff     <= '0;
         busy_ff      <= 1'b0;
         latch_ff     <= 1'b0;
         green_ff     <= DUR_RESET;
         red_ff       <= DUR_RESET;
         blink_ff     <= DUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            ticks_ff <= ticks_in;
            busy_ff  <= busy_in;
            latch_ff <= latch_in;
         end
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               ptl_pkg::CSR_GREEN_TICKS: green_ff <= csr_if.data;
               ptl_pkg::CSR_RED_TICKS:   red_ff   <= csr_if.data;
               ptl_pkg::CSR_BLINK_TICKS: blink_ff <= csr_if.data;
               default: begin
               end
            endcase
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         lamp_ff <= lamp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.car_green     = lamp_ff.car_green;
   assign rsp_if.car_yellow    = lamp_ff.car_yellow;
   assign rsp_if.car_red       = lamp_ff.car_red;
   assign rsp_if.walk_green    = lamp_ff.walk_green;
   assign rsp_if.walk_yellow   = lamp_ff.walk_yellow;
   assign rsp_if.walk_red      = lamp_ff.walk_red;
   assign rsp_if.ped_mode_lamp = lamp_ff.ped_mode_lamp;

endmodule

>>> tb/pedestrian_traffic_light_ctrl_top_tb.sv
// ---------------------------------------------------------------------------
// pedestrian_traffic_light_ctrl_top_tb: lamp sequencer testbench
// Drives time slots with tick and button flags, predicts the lamp state of
// every slot with a local phase model, and compares each response field by
// field. Durations are rewritten between test phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module pedestrian_traffic_light_ctrl_top_tb;

   localparam int TICK_W       = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 4;

   // index with no register behind it
   localparam logic [ptl_pkg::CSR_A_W-1:0] CSR_UNUSED_IDX = 2'd3;

   logic clock;
   logic reset;

   ptl_req_if req_bus ();
   ptl_rsp_if rsp_bus ();
   ptl_csr_if csr_bus ();

   pedestrian_traffic_light_ctrl_top #(
      .TICK_COUNT_WIDTH(TICK_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // light model state and durations
   ptl_pkg::phase_type        model_phase;
   logic [TICK_W-1:0]         model_ticks;
   logic                      model_busy;
   logic                      model_latch;
   logic [ptl_pkg::DUR_W-1:0] green_dur;
   logic [ptl_pkg::DUR_W-1:0] red_dur;
   logic [ptl_pkg::DUR_W-1:0] blink_dur;

   ptl_pkg::lamp_type pending_lamps [$];
   int       mismatch_count;
   int       cycle_count;
   bit       quiet_mode;
   int       rsp_stall_left;

   // clock generation
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // duration register that governs a phase
   function automatic logic [ptl_pkg::DUR_W-1:0] phase_limit(ptl_pkg::phase_type ph);
      ptl_pkg::dur_sel_type sel;
      case (ph)
         ptl_pkg::PH_CAR_GREEN:          sel = ptl_pkg::DUR_GREEN;
         ptl_pkg::PH_CAR_RED, ptl_pkg::PH_EXT_RED,
         ptl_pkg::PH_PED_WALK:           sel = ptl_pkg::DUR_RED;
         default:                        sel = ptl_pkg::DUR_BLINK;
      endcase
      case (sel)
         ptl_pkg::DUR_GREEN: return green_dur;
         ptl_pkg::DUR_RED:   return red_dur;
         default:            return blink_dur;
      endcase
   endfunction

   // phase that follows when a phase runs out
   function automatic ptl_pkg::phase_type following_phase(ptl_pkg::phase_type ph);
      case (ph)
         ptl_pkg::PH_CAR_GREEN:        return ptl_pkg::PH_CAR_YELLOW;
         ptl_pkg::PH_CAR_YELLOW:       return ptl_pkg::PH_CAR_RED;
         ptl_pkg::PH_CAR_RED:          return ptl_pkg::PH_YELLOW_AFTER_RED;
         ptl_pkg::PH_EXT_RED:          return ptl_pkg::PH_YELLOW_AFTER_EXT;
         ptl_pkg::PH_PED_BLINK_GREEN,
         ptl_pkg::PH_PED_BLINK_YELLOW: return ptl_pkg::PH_PED_WALK;
         ptl_pkg::PH_PED_WALK:         return ptl_pkg::PH_PED_FINAL_BLINK;
         default:                      return ptl_pkg::PH_CAR_GREEN;
      endcase
   endfunction

   function automatic void enter_light_phase(ptl_pkg::phase_type ph);
      model_phase = ph;
      model_ticks = '0;
      if (ph == ptl_pkg::PH_CAR_GREEN) begin
         model_busy  = 1'b0;
         model_latch = 1'b0;
      end
   endfunction

   // advance the light model by one slot and return its lamps
   function automatic ptl_pkg::lamp_type step_light_phase(logic tick, logic press);
      ptl_pkg::lamp_type lamps;
      logic        started;
      logic        blink_on;
      logic [TICK_W:0] next_count;
      started = 1'b0;
      if (press && !model_busy) begin
         if (model_phase == ptl_pkg::PH_CAR_RED) begin
            enter_light_phase(ptl_pkg::PH_EXT_RED);
            model_busy = 1'b1;
            started    = 1'b1;
         end else if (model_phase == ptl_pkg::PH_CAR_GREEN ||
                      model_phase == ptl_pkg::PH_CAR_YELLOW ||
                      model_phase == ptl_pkg::PH_YELLOW_AFTER_RED) begin
            enter_light_phase(model_phase == ptl_pkg::PH_CAR_GREEN
                              ? ptl_pkg::PH_PED_BLINK_GREEN
                              : ptl_pkg::PH_PED_BLINK_YELLOW);
            model_busy  = 1'b1;
            model_latch = 1'b1;
            started     = 1'b1;
         end
      end
      // a tick counts unless a press restarted the phase in this slot
      if (tick && !started) begin
         next_count = {1'b0, model_ticks} + 1'b1;
         if (next_count >= phase_limit(model_phase) || next_count[TICK_W])
            enter_light_phase(following_phase(model_phase));
         else
            model_ticks = next_count[TICK_W-1:0];
      end
      blink_on = ~model_ticks[0];
      lamps = '0;
      case (model_phase)
         ptl_pkg::PH_CAR_GREEN: begin
            lamps.car_green = 1'b1;
            lamps.walk_red  = 1'b1;
         end
         ptl_pkg::PH_CAR_YELLOW: begin
            lamps.car_yellow = blink_on;
            lamps.walk_red   = 1'b1;
         end
         ptl_pkg::PH_CAR_RED, ptl_pkg::PH_EXT_RED, ptl_pkg::PH_PED_WALK: begin
            lamps.car_red    = 1'b1;
            lamps.walk_green = 1'b1;
         end
         ptl_pkg::PH_YELLOW_AFTER_RED, ptl_pkg::PH_YELLOW_AFTER_EXT: begin
            lamps.car_yellow = blink_on;
            lamps.walk_green = 1'b1;
         end
         ptl_pkg::PH_PED_BLINK_GREEN: begin
            lamps.car_green   = 1'b1;
            lamps.car_yellow  = blink_on;
            lamps.walk_yellow = blink_on;
            lamps.walk_red    = 1'b1;
         end
         ptl_pkg::PH_PED_BLINK_YELLOW: begin
            lamps.car_yellow  = blink_on;
            lamps.walk_yellow = blink_on;
            lamps.walk_red    = 1'b1;
         end
         default: begin
            lamps.car_yellow  = blink_on;
            lamps.walk_yellow = blink_on;
            lamps.walk_green  = 1'b1;
         end
      endcase
      lamps.ped_mode_lamp = model_latch;
      return lamps;
   endfunction

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response sink with random stall bursts
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall_left--;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready  = 1'b0;
         rsp_stall_left = $urandom_range(0, 11);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   task automatic check_lamp(string field, logic want, logic got);
      if (want !== got) begin
         $error("%s mismatch: expected %0b actual %0b", field, want, got);
         mismatch_count++;
      end
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      ptl_pkg::lamp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_lamps.size() == 0) begin
            $error("response with no request pending");
            mismatch_count++;
         end else begin
            want = pending_lamps.pop_front();
            check_lamp("car_green",     want.car_green,     rsp_bus.car_green);
            check_lamp("car_yellow",    want.car_yellow,    rsp_bus.car_yellow);
            check_lamp("car_red",       want.car_red,       rsp_bus.car_red);
            check_lamp("walk_green",    want.walk_green,    rsp_bus.walk_green);
            check_lamp("walk_yellow",   want.walk_yellow,   rsp_bus.walk_yellow);
            check_lamp("walk_red",      want.walk_red,      rsp_bus.walk_red);
            check_lamp("ped_mode_lamp", want.ped_mode_lamp, rsp_bus.ped_mode_lamp);
         end
      end
   end

   // send one time slot, after an optional idle burst
   task automatic send_slot(logic tick, logic press);
      int gap;
      gap = (!quiet_mode && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.second_tick  = tick;
      req_bus.button_press = press;
      do @(posedge clock); while (!req_bus.ready);
      pending_lamps.push_back(step_light_phase(tick, press));
   endtask

   // stop sending and let every pending response arrive
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_lamps.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [ptl_pkg::CSR_A_W-1:0] idx,
                                 logic [ptl_pkg::DUR_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         ptl_pkg::CSR_GREEN_TICKS: green_dur = value;
         ptl_pkg::CSR_RED_TICKS:   red_dur   = value;
         ptl_pkg::CSR_BLINK_TICKS: blink_dur = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_durations(logic [ptl_pkg::DUR_W-1:0] g, logic [ptl_pkg::DUR_W-1:0] r,
                                logic [ptl_pkg::DUR_W-1:0] b);
      wait_drained();
      write_register(ptl_pkg::CSR_GREEN_TICKS, g);
      write_register(ptl_pkg::CSR_RED_TICKS, r);
      write_register(ptl_pkg::CSR_BLINK_TICKS, b);
   endtask

   // reset durations: green runs out on its fifth tick
   task automatic test_reset_durations();
      repeat (5) send_slot(1'b1, 1'b0);
      send_slot(1'b0, 1'b0);
   endtask

   // one-tick phases, zero green, presses in car green, yellow, red and busy phases
   task automatic test_short_phases();
      // each entry is {press, tick}
      logic [1:0] steps [$];
      steps = '{2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01, 2'b10, 2'b11,
                2'b01, 2'b10, 2'b01, 2'b11, 2'b01, 2'b01, 2'b01, 2'b01,
                2'b01, 2'b10, 2'b01};
      set_durations(8'd0, 8'd1, 8'd1);
      foreach (steps[i]) send_slot(steps[i][0], steps[i][1]);
   endtask

   // a write to an unused index must not disturb the durations
   task automatic test_unused_index();
      wait_drained();
      write_register(CSR_UNUSED_IDX, 8'd0);
      repeat (20) send_slot(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
   endtask

   // random slots under one duration setting
   task automatic test_random_slots(logic [ptl_pkg::DUR_W-1:0] g,
                                    logic [ptl_pkg::DUR_W-1:0] r,
                                    logic [ptl_pkg::DUR_W-1:0] b, int count, int tick_pct,
                                    int press_pct);
      set_durations(g, r, b);
      repeat (count)
         send_slot($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < press_pct);
   endtask

   initial begin
      reset          = 1'b1;
      quiet_mode     = 1'b0;
      rsp_stall_left = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      req_bus.valid        = 1'b0;
      req_bus.second_tick  = 1'b0;
      req_bus.button_press = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      green_dur   = 8'd5;
      red_dur     = 8'd5;
      blink_dur   = 8'd5;
      model_phase = ptl_pkg::PH_CAR_GREEN;
      model_ticks = '0;
      model_busy  = 1'b0;
      model_latch = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_durations();
      test_short_phases();
      test_unused_index();
      test_random_slots(8'd5, 8'd5, 8'd5, 120, 60, 10);
      test_random_slots(8'd1, 8'd1, 8'd1, 120, 50, 15);
      test_random_slots(8'd2, 8'd3, 8'd4, 120, 60, 12);
      test_random_slots(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                        8'($urandom_range(1, 6)), 120, 55, 12);
      test_random_slots(8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)),
                        8'($urandom_range(1, 4)), 100, 70, 20);
      test_random_slots(8'd255, 8'd255, 8'd255, 80, 90, 20);
      test_random_slots(8'd0, 8'd255, 8'd1, 60, 80, 25);
      quiet_mode = 1'b1;
      test_random_slots(8'd3, 8'd2, 8'd2, 120, 60, 12);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
